[rtl/ede_pkg.sv]
// ----------------------------------------------------------------------------
// ede_pkg: shared types for the edit distance engine
// Opcodes, controller states and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ede_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_PROCESS = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic do_clear;
        logic do_append;
        logic set_drop;
        logic start_walk;
        logic walk_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic ref_full;
        logic ref_zero;
        logic query_full;
        logic query_zero;
        logic walk_last;
        logic out_busy;
    } status_t;

endpackage

[rtl/ede_ctrl.sv]
// ----------------------------------------------------------------------------
// ede_ctrl: controller state machine
// Decodes each item and sequences the datapath through the row walk and
// the result hand-off.
// ----------------------------------------------------------------------------
module ede_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ede_pkg::status_t status,
    output ede_pkg::cmd_t    cmd
);
    import ede_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (status.op)
                    OP_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                    end
                    OP_APPEND:
                    begin
                        // Appends after the first query byte are ignored.
                        if (status.query_zero)
                        begin
                            if (status.ref_full)
                            begin
                                cmd.set_drop = 1'b1;
                            end
                            else
                            begin
                                cmd.do_append = 1'b1;
                            end
                        end
                    end
                    OP_PROCESS:
                    begin
                        if (status.query_full)
                        begin
                            cmd.set_drop = 1'b1;
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            if (!status.ref_zero)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                    end
                    OP_FINISH:
                    begin
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/ede_datapath.sv]
// ----------------------------------------------------------------------------
// ede_datapath: reference store, cost row and output register
// Holds the reference bytes and the cost row in memories and applies one
// step of the edit distance recurrence per cycle during a row walk.
// ----------------------------------------------------------------------------
module ede_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ede_pkg::cmd_t    cmd,
    output ede_pkg::status_t status,
    input  logic [1:0]       item_op,
    input  logic [7:0]       item_char,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [6:0]       out_distance,
    output logic             out_overflow
);
    import ede_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LW-1:0] MaxLenVal = LW'(MAX_LEN);
    localparam logic [LW-1:0] OneVal    = LW'(1);

    // Entry k of cost_mem holds cost row entry k + 1; entry zero is row0_reg.
    logic [7:0]    ref_mem  [MAX_LEN];
    logic [LW-1:0] cost_mem [MAX_LEN];

    op_t           op_reg;
    logic [7:0]    char_reg;
    logic [LW-1:0] ref_len_reg;
    logic [LW-1:0] query_cnt_reg;
    logic          drop_reg;
    logic [LW-1:0] row0_reg;
    logic [LW-1:0] left_reg;
    logic [LW-1:0] corner_reg;
    logic [LW-1:0] j_reg;
    logic [7:0]    rd_ref_reg;
    logic [LW-1:0] rd_cost_reg;
    logic          out_valid_reg;
    logic [6:0]    out_distance_reg;
    logic          out_overflow_reg;

    logic [LW-1:0] j_plus;
    logic [LW-1:0] query_plus;
    logic [LW-1:0] ref_plus;
    logic [LW-1:0] ref_minus;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] min_a;
    logic [LW-1:0] min_b;
    logic [LW-1:0] cost_new;
    logic [LW-1:0] final_cost;
    logic [LW+6:0] final_ext;

    assign j_plus     = j_reg + OneVal;
    assign query_plus = query_cnt_reg + OneVal;
    assign ref_plus   = ref_len_reg + OneVal;
    assign ref_minus  = ref_len_reg - OneVal;

    always_comb
    begin
        priority if (cmd.walk_step)
        begin
            rd_addr = j_plus[AW-1:0];
        end
        else if (cmd.start_walk)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = ref_minus[AW-1:0];
        end
    end

    // One step of the recurrence: match takes the diagonal, otherwise one
    // more than the smallest of upper, diagonal and left.
    always_comb
    begin
        min_a = (rd_cost_reg < corner_reg) ? rd_cost_reg : corner_reg;
        min_b = (min_a < left_reg) ? min_a : left_reg;
        if (rd_ref_reg == char_reg)
        begin
            cost_new = corner_reg;
        end
        else
        begin
            cost_new = min_b + OneVal;
        end
    end

    assign final_cost = (ref_len_reg == '0) ? row0_reg : rd_cost_reg;
    assign final_ext  = {7'd0, final_cost};

    always_ff @(posedge clk)
    begin
        if (cmd.do_append)
        begin
            ref_mem[ref_len_reg[AW-1:0]]  <= char_reg;
            cost_mem[ref_len_reg[AW-1:0]] <= ref_plus;
        end
        else if (cmd.walk_step)
        begin
            cost_mem[j_reg[AW-1:0]] <= cost_new;
        end
        rd_ref_reg  <= ref_mem[rd_addr];
        rd_cost_reg <= cost_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg   <= op_t'(item_op);
            char_reg <= item_char;
        end
        if (cmd.start_walk)
        begin
            left_reg   <= query_plus;
            corner_reg <= query_cnt_reg;
        end
        else if (cmd.walk_step)
        begin
            left_reg   <= cost_new;
            corner_reg <= rd_cost_reg;
        end
        if (cmd.load_out)
        begin
            out_distance_reg <= final_ext[6:0];
            out_overflow_reg <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg   <= '0;
            query_cnt_reg <= '0;
            drop_reg      <= 1'b0;
            row0_reg      <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                ref_len_reg   <= '0;
                query_cnt_reg <= '0;
                drop_reg      <= 1'b0;
                row0_reg      <= '0;
            end
            if (cmd.do_append)
            begin
                ref_len_reg <= ref_plus;
            end
            if (cmd.set_drop)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.start_walk)
            begin
                query_cnt_reg <= query_plus;
                row0_reg      <= query_plus;
                j_reg         <= '0;
            end
            else if (cmd.walk_step)
            begin
                j_reg <= j_plus;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.op         = op_reg;
    assign status.ref_full   = (ref_len_reg == MaxLenVal);
    assign status.ref_zero   = (ref_len_reg == '0);
    assign status.query_full = (query_cnt_reg == MaxLenVal);
    assign status.query_zero = (query_cnt_reg == '0);
    assign status.walk_last  = (j_plus == ref_len_reg);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_distance = out_distance_reg;
    assign out_overflow = out_overflow_reg;

endmodule

[rtl/edit_distance_engine_unit.sv]
// ----------------------------------------------------------------------------
// edit_distance_engine_unit: Levenshtein edit distance engine
// A query byte starts a walk of the cost row, and finish moves the
// distance to the output register. One item is in work at a time.
// Reset clears the lengths, the drop flag, cost row entry zero and the
// output valid; the byte and cost memories are not cleared.
// ----------------------------------------------------------------------------
// Items arrive on the slave side with the opcode in tuser and the byte in
// tdata. Clear starts a new comparison, append extends the reference string
// and seeds its cost row entry with its position, process takes one query
// byte and rewrites the cost row in place, and finish emits the distance
// between the two strings seen so far.
//
// The controller walks the cost row one entry per cycle. The memories are
// read one entry ahead, so each cycle writes entry j while fetching entry
// j + 1, and the left and diagonal neighbors live in registers. The result
// sits in an output register, so the engine takes the next item while a
// distance still waits on the master side; a further finish holds in its
// emit state until the output register is free.
// ----------------------------------------------------------------------------
module edit_distance_engine_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [1:0] s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] distance, [7] zero fill
    output logic       m_tuser    // [0] overflow
);
    import ede_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic [6:0] distance;

    ede_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    ede_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item_op      (s_tuser),
        .item_char    (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_distance (distance),
        .out_overflow (m_tuser)
    );

    assign m_tdata = {1'b0, distance};

endmodule
